// ----- design/arpt_pkg.sv -----
// Shared types, codes and defaults for the address range policy table.
package arpt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int PAGE_SHIFT_DEF  = 21;

    localparam int ADDR_W   = 64;
    localparam int POLICY_W = 2;

    // Request function codes
    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_COLLAPSED = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Configuration register indexes
    localparam logic REG_FALLBACK_POLICY = 1'b0;

    localparam logic [POLICY_W-1:0] FALLBACK_RESET = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]   start_addr;
        logic [ADDR_W-1:0]   end_addr;
        logic [POLICY_W-1:0] policy;
    } t_entry;

endpackage

// ----- design/arpt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module arpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/address_range_policy_table.sv -----
// Top level of the address range policy table: sequencer, range RAM, APB register.
//
// Holds up to TABLE_DEPTH page-aligned address ranges [start, end), each with a
// tiering policy, sorted by start address in a single RAM. A request is taken
// when start is high and busy is low; its one result shows on the o_ ports for
// exactly one cycle with o_valid high and cannot be held off by the receiver.
// The single RAM read port is walked one entry per cycle:
//   register: raw check and align, aligned and full checks, then a move for
//             each stored entry that starts above the new range and the insert;
//             empty ranges end at the raw check, collapsed or full at the aligned;
//   lookup:   walks up from entry 0 to the first hit, or over all used entries;
//   clear and the unused function code: answered from idle, busy never rises.
// Inserts scan from the top entry down, moving each larger entry up by one
// slot, so the search and the shift are one pass. Equal starts land after the
// entries already stored. The fallback policy register sits at byte address 0
// of the APB port and must only be written while the block is idle.
module address_range_policy_table
    import arpt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_func,
    input  logic [ADDR_W-1:0]   i_range_start,
    input  logic [ADDR_W-1:0]   i_range_end,
    input  logic [POLICY_W-1:0] i_range_policy,
    input  logic [ADDR_W-1:0]   i_query_address,
    // result
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [POLICY_W-1:0] o_match_policy,
    output logic                o_no_match,
    output logic [3:0]          o_match_index,
    output logic [ADDR_W-1:0]   o_match_start,
    output logic [ADDR_W-1:0]   o_match_end,
    output logic [4:0]          o_entries_used,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [ADDR_W-1:0] PageMask = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
    localparam logic [CW-1:0] DepthCount = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,  // raw range check, align
        S_PLACE = 5'b00100,  // aligned check, full check
        S_SHIFT = 5'b01000,  // top-down move and insert
        S_SCAN  = 5'b10000   // lookup walk
    } t_state;

    t_state r_state;

    logic [CW-1:0]         r_used;
    logic [CW-1:0]         r_idx;
    logic [POLICY_W-1:0]   r_fallback;

    logic [ADDR_W-1:0]     r_s;
    logic [ADDR_W-1:0]     r_e;
    logic [POLICY_W-1:0]   r_pol;
    logic [ADDR_W-1:0]     r_va;

    logic                  r_valid;
    logic [1:0]            r_status;
    logic [POLICY_W-1:0]   r_mpol;
    logic                  r_fb;
    logic [3:0]            r_midx;
    logic [ADDR_W-1:0]     r_mstart;
    logic [ADDR_W-1:0]     r_mend;

    // RAM port signals
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    t_entry                w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [$bits(t_entry)-1:0] w_rdata_raw;
    t_entry                w_rd;

    logic                  w_accept;
    logic                  w_cfg_wr;
    logic                  w_move;
    logic                  w_hit;
    logic                  w_scan_end;
    logic [ADDR_W-1:0]     w_s_al;
    logic [ADDR_W-1:0]     w_e_al;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign w_rd     = t_entry'(w_rdata_raw);

    // page alignment of the raw range
    assign w_s_al = r_s & ~PageMask;
    assign w_e_al = (r_e == '1) ? r_e : ((r_e + PageMask) & ~PageMask);

    // entry below the slot being filled starts above the new range: move it up
    assign w_move     = (r_idx != '0) && (w_rd.start_addr > r_s);
    assign w_scan_end = (r_idx == r_used);
    assign w_hit      = !w_scan_end && (r_va >= w_rd.start_addr) && (r_va < w_rd.end_addr);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = '{start_addr: r_s, end_addr: r_e, policy: r_pol};
        w_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                w_raddr = '0;
            end
            S_CHECK: begin
                w_raddr = '0;
            end
            S_PLACE: begin
                w_raddr = AW'(r_used - CW'(1));
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_raddr = AW'(r_idx - CW'(2));
                if (w_move) begin
                    w_wdata = w_rd;
                end
            end
            S_SCAN: begin
                w_raddr = AW'(r_idx + CW'(1));
            end
            default: begin
                w_raddr = '0;
            end
        endcase
    end

    arpt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_idx      <= '0;
            r_valid    <= 1'b0;
            r_fallback <= FALLBACK_RESET;
        end else begin
            r_valid <= 1'b0;
            if (w_cfg_wr && paddr[2] == REG_FALLBACK_POLICY) begin
                r_fallback <= pwdata[POLICY_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx <= '0;
                        case (i_func)
                            FUNC_REGISTER: r_state <= S_CHECK;
                            FUNC_LOOKUP:   r_state <= S_SCAN;
                            FUNC_CLEAR: begin
                                r_used  <= '0;
                                r_valid <= 1'b1;
                            end
                            default: r_valid <= 1'b1;
                        endcase
                    end
                end
                S_CHECK: begin
                    if (r_e <= r_s) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    if (r_e <= r_s || r_used == DepthCount) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_used;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (w_move) begin
                        r_idx <= r_idx - CW'(1);
                    end else begin
                        r_used  <= r_used + CW'(1);
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (w_hit || w_scan_end) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request payload and result fields
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_s      <= i_range_start;
                    r_e      <= i_range_end;
                    r_pol    <= i_range_policy;
                    r_va     <= i_query_address;
                    r_status <= ST_OK;
                    r_mpol   <= '0;
                    r_fb     <= 1'b0;
                    r_midx   <= '0;
                    r_mstart <= '0;
                    r_mend   <= '0;
                end
            end
            S_CHECK: begin
                if (r_e <= r_s) begin
                    r_status <= ST_BAD_RANGE;
                end
                r_s <= w_s_al;
                r_e <= w_e_al;
            end
            S_PLACE: begin
                if (r_e <= r_s) begin
                    r_status <= ST_COLLAPSED;
                end else if (r_used == DepthCount) begin
                    r_status <= ST_FULL;
                end
            end
            S_SHIFT: begin
                r_status <= ST_OK;
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    r_mpol   <= r_fallback;
                    r_fb     <= 1'b1;
                    r_midx   <= '0;
                    r_mstart <= '0;
                    r_mend   <= '1;
                end else if (w_hit) begin
                    r_mpol   <= w_rd.policy;
                    r_fb     <= 1'b0;
                    r_midx   <= 4'(r_idx);
                    r_mstart <= w_rd.start_addr;
                    r_mend   <= w_rd.end_addr;
                end
            end
            default: begin
                r_status <= ST_OK;
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_match_policy = r_mpol;
    assign o_no_match     = r_fb;
    assign o_match_index  = r_midx;
    assign o_match_start  = r_mstart;
    assign o_match_end    = r_mend;
    assign o_entries_used = 5'(r_used);

    // APB register access
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FALLBACK_POLICY) ? 32'(r_fallback) : '0;

endmodule

// ----- design/arpt_checker.sv -----
// Port-level assertions for the address range policy table, bound to the top.
module arpt_checker
    import arpt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [1:0]          i_func,
    input logic                o_valid,
    input logic [1:0]          o_status,
    input logic [POLICY_W-1:0] o_match_policy,
    input logic                o_no_match,
    input logic [3:0]          o_match_index,
    input logic [ADDR_W-1:0]   o_match_start,
    input logic [ADDR_W-1:0]   o_match_end,
    input logic [4:0]          o_entries_used
);

    // result only once the sequencer has released
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_CLEAR) |=>
            (o_valid && o_entries_used == 5'd0 && o_status == ST_OK))
        else $error("clear did not empty the table");

    a_register_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_REGISTER || i_func == FUNC_LOOKUP))
            |=> (busy && !o_valid))
        else $error("table walk did not hold busy");

    a_fallback_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_match) |->
            (o_match_start == '0 && o_match_end == '1 && o_match_index == 4'd0
             && o_status == ST_OK))
        else $error("malformed fallback result");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (!o_no_match && o_match_policy == '0 && o_match_start == '0))
        else $error("rejected register carries match data");

endmodule

bind address_range_policy_table arpt_checker u_arpt_checker (.*);
